/* rtl/cob_pkg.sv */
package cob_pkg;

  localparam int SHAPE_DEPTH    = 4096;
  localparam int MAX_CURSOR_DIM = 64;

  localparam int SHAPE_AW = $clog2(SHAPE_DEPTH);
  // wide enough for any byte or word index the shape lookup can form
  localparam int IDX_W    = 17;

  // cursor types
  localparam logic [1:0] TYPE_COLOR  = 2'd0;
  localparam logic [1:0] TYPE_MONO   = 2'd1;
  localparam logic [1:0] TYPE_MASKED = 2'd2;
  localparam logic [1:0] TYPE_NONE   = 2'd3;

  // transaction kinds
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  // register indexes
  localparam logic [2:0] REG_TYPE   = 3'd0;
  localparam logic [2:0] REG_ENABLE = 3'd1;
  localparam logic [2:0] REG_X      = 3'd2;
  localparam logic [2:0] REG_Y      = 3'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;
  localparam logic [2:0] REG_PITCH  = 3'd6;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [31:0] pix;
    logic [1:0]  ctype;
    logic        cov;
    logic [1:0]  sel_a;
    logic [1:0]  sel_b;
    logic [2:0]  bit_idx;
    logic        oob_a;
    logic        oob_b;
  } cob_op_t;

  // floor(t / 255) for t below 65280
  function automatic logic [7:0] div255(input logic [16:0] t);
    logic [16:0] s;
    begin
      s = t + 17'd1 + {8'd0, t[16:8]};
      div255 = s[15:8];
    end
  endfunction

endpackage

/* rtl/cob_blend.sv */
module cob_blend (
  input  cob_pkg::cob_op_t op,
  input  logic [31:0]      word_a,
  input  logic [31:0]      word_b,
  output logic [31:0]      pixel_out
);

  logic [31:0] wa;
  logic [31:0] wb;
  logic [7:0]  byte_a;
  logic [7:0]  byte_b;
  logic [31:0] and_m;
  logic [31:0] xor_m;
  logic [7:0]  alpha;
  logic [7:0]  inv_a;
  logic [31:0] blended;
  logic [15:0] prod [3];
  logic [7:0]  q [3];

  // reads past the end of the shape store give zero
  assign wa = op.oob_a ? 32'd0 : word_a;
  assign wb = op.oob_b ? 32'd0 : word_b;

  assign byte_a = wa[8*op.sel_a +: 8];
  assign byte_b = wb[8*op.sel_b +: 8];
  assign and_m  = {32{byte_a[op.bit_idx]}};
  assign xor_m  = {32{byte_b[op.bit_idx]}};

  assign alpha = wa[31:24];
  assign inv_a = 8'hFF - alpha;

  always_comb begin
    blended[31:24] = op.pix[31:24];
    for (int c = 0; c < 3; c++) begin
      prod[c] = op.pix[8*c +: 8] * inv_a;
      q[c] = cob_pkg::div255({1'b0, prod[c]} + 17'd127);
      blended[8*c +: 8] = wa[8*c +: 8] + q[c];
    end
  end

  always_comb begin
    pixel_out = op.pix;
    if (op.cov) begin
      case (op.ctype)
        cob_pkg::TYPE_MONO:   pixel_out = (op.pix & and_m) ^ xor_m;
        cob_pkg::TYPE_COLOR:  pixel_out = (alpha == cob_pkg::ALPHA_OPAQUE) ? wa : blended;
        cob_pkg::TYPE_MASKED: pixel_out = (alpha == cob_pkg::ALPHA_OPAQUE) ? (op.pix ^ wa) : wa;
        default:              pixel_out = op.pix;
      endcase
    end
  end

endmodule

/* rtl/cursor_overlay_blend_top.sv */
// a pixel transaction is registered into stage 1 with its shape reads, and from there
//   into the output register once that register is free or being read
// throughput: one transaction per cycle, writes and pixels alike, while out_ready does
//   not stall; one write and two read ports give both mono mask reads in the same cycle
// shape writes take effect at their accept edge and produce no result
// reset (rst_n low, synchronous): config registers cleared, pipeline emptied;
//   shape memory contents are undefined until written
module cursor_overlay_blend_top (
  input  logic        clk,
  input  logic        rst_n,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [11:0] in_shape_addr,
  input  logic [31:0] in_shape_data,
  input  logic [11:0] in_pixel_x,
  input  logic [11:0] in_pixel_y,
  input  logic [31:0] in_pixel_in,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pixel_out,
  output logic        out_covered
);

  localparam int AW = cob_pkg::SHAPE_AW;
  localparam int IW = cob_pkg::IDX_W;

  // configuration registers
  logic [1:0]  type_r;
  logic        enable_r;
  logic [12:0] cx_r;
  logic [12:0] cy_r;
  logic [6:0]  width_r;
  logic [7:0]  height_r;
  logic [8:0]  pitch_r;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r   <= cob_pkg::TYPE_COLOR;
      enable_r <= 1'b0;
      cx_r     <= '0;
      cy_r     <= '0;
      width_r  <= '0;
      height_r <= '0;
      pitch_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        cob_pkg::REG_TYPE:   type_r   <= pwdata[1:0];
        cob_pkg::REG_ENABLE: enable_r <= pwdata[0];
        cob_pkg::REG_X:      cx_r     <= pwdata[12:0];
        cob_pkg::REG_Y:      cy_r     <= pwdata[12:0];
        cob_pkg::REG_WIDTH:  width_r  <= pwdata[6:0];
        cob_pkg::REG_HEIGHT: height_r <= pwdata[7:0];
        cob_pkg::REG_PITCH:  pitch_r  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      cob_pkg::REG_TYPE:   prdata = {30'd0, type_r};
      cob_pkg::REG_ENABLE: prdata = {31'd0, enable_r};
      cob_pkg::REG_X:      prdata = {{19{cx_r[12]}}, cx_r};
      cob_pkg::REG_Y:      prdata = {{19{cy_r[12]}}, cy_r};
      cob_pkg::REG_WIDTH:  prdata = {25'd0, width_r};
      cob_pkg::REG_HEIGHT: prdata = {24'd0, height_r};
      cob_pkg::REG_PITCH:  prdata = {23'd0, pitch_r};
      default:             prdata = 32'd0;
    endcase
  end

  // pipeline control: stage 1 holds memory read data, the output register follows
  logic s1_v_r;
  logic out_v_r;
  logic adv;
  logic in_acc;
  logic px_acc;
  logic wr_acc;

  assign adv      = !out_v_r || out_ready;
  assign in_ready = !s1_v_r || adv;
  assign in_acc   = in_valid && in_ready;
  assign px_acc   = in_acc && (in_action == cob_pkg::ACT_PIXEL);
  assign wr_acc   = in_acc && (in_action == cob_pkg::ACT_WRITE);

  // coverage test and shape addressing, done in the accept cycle
  logic        mono;
  logic [6:0]  w_sat;
  logic [7:0]  h_sat;
  logic [7:0]  rows;
  logic [13:0] dx;
  logic [13:0] dy;
  logic        cov;
  logic [5:0]  ux;
  logic [6:0]  uy;
  logic [8:0]  mul_rhs;
  logic [15:0] mul_a;
  logic [16:0] mul_b;
  logic [7:0]  uy_x;
  logic [IW-1:0] byte_a;
  logic [IW-1:0] byte_b;
  logic [IW-1:0] idx_a;
  logic [IW-1:0] idx_b;

  assign mono  = (type_r == cob_pkg::TYPE_MONO);
  assign w_sat = (width_r > 7'(cob_pkg::MAX_CURSOR_DIM)) ? 7'(cob_pkg::MAX_CURSOR_DIM) : width_r;
  assign h_sat = (height_r > 8'(2 * cob_pkg::MAX_CURSOR_DIM)) ?
                 8'(2 * cob_pkg::MAX_CURSOR_DIM) : height_r;
  assign rows  = mono ? {1'b0, h_sat[7:1]} : h_sat;

  // 14-bit signed offsets from the cursor corner
  assign dx = {2'b00, in_pixel_x} - {cx_r[12], cx_r};
  assign dy = {2'b00, in_pixel_y} - {cy_r[12], cy_r};

  assign cov = enable_r && (type_r != cob_pkg::TYPE_NONE) && !dx[13] && !dy[13] &&
               (dx[12:0] < {6'd0, w_sat}) && (dy[12:0] < {5'd0, rows});

  assign ux = dx[5:0];
  assign uy = dy[6:0];

  // one multiplier serves the color stride or the mask pitch
  assign mul_rhs = mono ? pitch_r : {2'b00, w_sat};
  assign mul_a   = uy * mul_rhs;
  assign uy_x    = {1'b0, uy} + rows;
  assign mul_b   = uy_x * pitch_r;

  assign byte_a = {1'b0, mul_a} + {14'd0, ux[5:3]};
  assign byte_b = mul_b + {14'd0, ux[5:3]};
  assign idx_a  = mono ? {2'b00, byte_a[IW-1:2]} : ({1'b0, mul_a} + {11'd0, ux});
  assign idx_b  = {2'b00, byte_b[IW-1:2]};

  // shape memory: one write port, two registered read ports
  logic [31:0] shape_mem [cob_pkg::SHAPE_DEPTH];
  logic [31:0] rd_a_r;
  logic [31:0] rd_b_r;
  logic [IW-1:0] waddr;

  assign waddr = {{(IW-12){1'b0}}, in_shape_addr};

  always_ff @(posedge clk) begin
    if (wr_acc && (waddr < IW'(cob_pkg::SHAPE_DEPTH))) begin
      shape_mem[waddr[AW-1:0]] <= in_shape_data;
    end
    if (px_acc) begin
      rd_a_r <= shape_mem[idx_a[AW-1:0]];
      rd_b_r <= shape_mem[idx_b[AW-1:0]];
    end
  end

  // stage 1 operation record
  cob_pkg::cob_op_t op_r;

  always_ff @(posedge clk) begin
    if (px_acc) begin
      op_r.pix     <= in_pixel_in;
      op_r.ctype   <= type_r;
      op_r.cov     <= cov;
      op_r.sel_a   <= mono ? byte_a[1:0] : 2'd0;
      op_r.sel_b   <= byte_b[1:0];
      op_r.bit_idx <= 3'd7 - ux[2:0];
      op_r.oob_a   <= (idx_a >= IW'(cob_pkg::SHAPE_DEPTH));
      op_r.oob_b   <= (idx_b >= IW'(cob_pkg::SHAPE_DEPTH));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= px_acc;
    end
  end

  // compositing
  logic [31:0] blend_px;

  cob_blend u_blend (
    .op        (op_r),
    .word_a    (rd_a_r),
    .word_b    (rd_b_r),
    .pixel_out (blend_px)
  );

  // output register
  logic [31:0] out_px_r;
  logic        out_cov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      out_px_r  <= blend_px;
      out_cov_r <= op_r.cov;
    end
  end

  assign out_valid     = out_v_r;
  assign out_pixel_out = out_px_r;
  assign out_covered   = out_cov_r;

`ifndef SYNTH
  // a pixel transaction always lands in stage 1
  a_pixel_enters: assert property (@(posedge clk) disable iff (!rst_n)
    px_acc |=> s1_v_r)
    else $error("pixel transaction lost before stage 1");

  // an empty stage 1 never refuses a transaction
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_ready)
    else $error("input stalled with empty stage 1");

  // a covered result requires the cursor to be on and a drawable type
  a_cov_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_cov_r) |-> (enable_r && (type_r != cob_pkg::TYPE_NONE)))
    else $error("covered result with cursor disabled");

  // stage 1 data moves on only when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ready) |=> (out_v_r && $stable(out_px_r)))
    else $error("held result overwritten");
`endif

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT = 2000;  // cycles without any transaction before giving up
  localparam int SETTLE_CYCLES = 8;   // pipeline is two deep; writes give no result
  localparam int ITEM_TARGET = 1700;  // minimum input transactions queued over the whole run

  typedef struct {
    logic        action;
    logic [11:0] shape_addr;
    logic [31:0] shape_data;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [31:0] pixel_in;
  } overlay_txn_t;

  typedef struct {
    logic [31:0] pixel_out;
    logic        covered;
  } overlay_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_action = cob_pkg::ACT_WRITE;
  logic [11:0] in_shape_addr = '0;
  logic [31:0] in_shape_data = '0;
  logic [11:0] in_pixel_x = '0;
  logic [11:0] in_pixel_y = '0;
  logic [31:0] in_pixel_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_pixel_out;
  logic        out_covered;

  cursor_overlay_blend_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_shape_addr (in_shape_addr),
    .in_shape_data (in_shape_data),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_covered   (out_covered)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cursor registers as the block should hold them, updated at each register write
  logic [1:0]        cfg_type = cob_pkg::TYPE_COLOR;
  logic              cfg_enable = 1'b0;
  logic signed [12:0] cfg_x = '0;
  logic signed [12:0] cfg_y = '0;
  logic [6:0]        cfg_width = '0;
  logic [7:0]        cfg_height = '0;
  logic [8:0]        cfg_pitch = '0;

  // shape memory image, written as write transactions are accepted
  logic [31:0] shape_image [cob_pkg::SHAPE_DEPTH];
  // words the stimulus has already loaded; pixels never read a word left unloaded
  bit          shape_loaded [cob_pkg::SHAPE_DEPTH];

  overlay_txn_t    pending_items[$];
  overlay_result_t expected_pixels[$];
  overlay_txn_t    on_bus;

  int error_count = 0;
  int pixels_checked = 0;
  int covered_seen = 0;
  int writes_accepted = 0;
  int settings_used = 0;
  int items_queued = 0;

  // gap lengths: mostly none or short, a few long, and now and then a long run without gaps
  function automatic int idle_length(inout int burst_left);
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 15) begin
      burst_left = $urandom_range(40, 160);
      return 0;
    end
    if (r < 550) return 0;
    if (r < 850) return $urandom_range(1, 3);
    if (r < 970) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // finds where the cursor shape covers a frame pixel and which shape words it reads;
  // monochrome gets the and/xor byte lanes and the bit within the byte
  function automatic bit locate_shape(input int px, input int py,
                                      output int unsigned word_a, output int unsigned word_b,
                                      output logic [1:0] lane_a, output logic [1:0] lane_b,
                                      output logic [2:0] bit_sel);
    int w, rows, dx, dy;
    int unsigned byte_a, byte_b;
    w = (cfg_width > cob_pkg::MAX_CURSOR_DIM) ? cob_pkg::MAX_CURSOR_DIM : cfg_width;
    rows = (cfg_height > 2 * cob_pkg::MAX_CURSOR_DIM) ? 2 * cob_pkg::MAX_CURSOR_DIM :
           cfg_height;
    if (cfg_type == cob_pkg::TYPE_MONO) rows = rows / 2;
    dx = px - int'(cfg_x);
    dy = py - int'(cfg_y);
    word_a = 0;
    word_b = 0;
    lane_a = '0;
    lane_b = '0;
    bit_sel = '0;
    if (!cfg_enable || cfg_type == cob_pkg::TYPE_NONE) return 1'b0;
    if (dx < 0 || dy < 0 || dx >= w || dy >= rows) return 1'b0;
    if (cfg_type == cob_pkg::TYPE_MONO) begin
      // the xor plane sits one half-height below the and plane
      byte_a = dy * cfg_pitch + dx / 8;
      byte_b = (dy + rows) * cfg_pitch + dx / 8;
      word_a = byte_a >> 2;
      word_b = byte_b >> 2;
      lane_a = byte_a[1:0];
      lane_b = byte_b[1:0];
      bit_sel = 3'(7 - dx % 8);
    end else begin
      // color row stride is the clamped width
      word_a = dy * w + dx;
      word_b = word_a;
    end
    return 1'b1;
  endfunction

  // reads past the end of the shape memory return zero
  function automatic logic [31:0] shape_word(input int unsigned idx);
    if (idx >= cob_pkg::SHAPE_DEPTH) return '0;
    return shape_image[idx];
  endfunction

  function automatic overlay_result_t composite_pixel(input int px, input int py,
                                                      input logic [31:0] pix);
    overlay_result_t res;
    int unsigned wa, wb;
    logic [1:0]  la, lb;
    logic [2:0]  bs;
    logic [7:0]  and_byte, xor_byte;
    logic [31:0] cur;
    int          p, k, a;
    res.pixel_out = pix;
    res.covered = 1'b0;
    if (!locate_shape(px, py, wa, wb, la, lb, bs)) return res;
    res.covered = 1'b1;
    case (cfg_type)
      cob_pkg::TYPE_MONO: begin
        and_byte = 8'(shape_word(wa) >> (8 * la));
        xor_byte = 8'(shape_word(wb) >> (8 * lb));
        res.pixel_out = (pix & {32{and_byte[bs]}}) ^ {32{xor_byte[bs]}};
      end
      cob_pkg::TYPE_MASKED: begin
        cur = shape_word(wa);
        res.pixel_out = (cur[31:24] == cob_pkg::ALPHA_OPAQUE) ? (pix ^ cur) : cur;
      end
      cob_pkg::TYPE_COLOR: begin
        cur = shape_word(wa);
        if (cur[31:24] == cob_pkg::ALPHA_OPAQUE) begin
          res.pixel_out = cur;
        end else begin
          // premultiplied: cursor + frame * (1 - alpha), rounded, wrapping at 8 bits
          a = cur[31:24];
          for (int c = 0; c < 3; c++) begin
            p = pix[8*c +: 8];
            k = cur[8*c +: 8];
            res.pixel_out[8*c +: 8] = 8'(k + (p * (255 - a) + 127) / 255);
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // shape words with opaque and fully transparent alpha well represented
  function automatic logic [31:0] shape_word_pattern();
    logic [7:0] alpha;
    case ($urandom_range(0, 3))
      0: alpha = 8'h00;
      1: alpha = cob_pkg::ALPHA_OPAQUE;
      default: alpha = 8'($urandom());
    endcase
    return {alpha, 24'($urandom())};
  endfunction

  function automatic void queue_write(input logic [11:0] addr, input logic [31:0] data);
    overlay_txn_t t;
    t.action = cob_pkg::ACT_WRITE;
    t.shape_addr = addr;
    t.shape_data = data;
    t.pixel_x = 12'($urandom());
    t.pixel_y = 12'($urandom());
    t.pixel_in = $urandom();
    if (int'(addr) < cob_pkg::SHAPE_DEPTH) shape_loaded[addr] = 1'b1;
    pending_items.push_back(t);
    items_queued++;
  endfunction

  // a pixel transaction; any shape word it reads that is still unloaded gets loaded first
  function automatic void queue_pixel(input int px, input int py, input logic [31:0] pix);
    overlay_txn_t t;
    int unsigned  wa, wb;
    logic [1:0]   la, lb;
    logic [2:0]   bs;
    if (locate_shape(px, py, wa, wb, la, lb, bs)) begin
      if (wa < cob_pkg::SHAPE_DEPTH && !shape_loaded[wa])
        queue_write(12'(wa), shape_word_pattern());
      if (wb < cob_pkg::SHAPE_DEPTH && !shape_loaded[wb])
        queue_write(12'(wb), shape_word_pattern());
    end
    t.action = cob_pkg::ACT_PIXEL;
    t.shape_addr = 12'($urandom());
    t.shape_data = $urandom();
    t.pixel_x = 12'(px);
    t.pixel_y = 12'(py);
    t.pixel_in = pix;
    pending_items.push_back(t);
    items_queued++;
  endfunction

  // mostly pixels around the cursor, some anywhere in the frame, some stray shape writes
  function automatic void queue_random_item();
    int r, w, h, px, py;
    logic [31:0] pix;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      queue_write(12'($urandom()), shape_word_pattern());
      return;
    end
    w = (cfg_width > cob_pkg::MAX_CURSOR_DIM) ? cob_pkg::MAX_CURSOR_DIM : cfg_width;
    h = (cfg_height > 2 * cob_pkg::MAX_CURSOR_DIM) ? 2 * cob_pkg::MAX_CURSOR_DIM :
        cfg_height;
    px = int'(cfg_x) + $urandom_range(0, w + 7) - 4;
    py = int'(cfg_y) + $urandom_range(0, h + 5) - 3;
    if (r < 28 || px < 0 || px > 4095) px = $urandom_range(0, 4095);
    if (r < 28 || py < 0 || py > 4095) py = $urandom_range(0, 4095);
    case ($urandom_range(0, 9))
      0: pix = 32'h0000_0000;
      1: pix = 32'hFFFF_FFFF;
      default: pix = $urandom();
    endcase
    queue_pixel(px, py, pix);
  endfunction

  // extremes, positions near either frame edge, and anywhere in the signed range
  function automatic int pick_position();
    case ($urandom_range(0, 7))
      0: return -4096;
      1: return 4095;
      2: return int'($urandom_range(0, 8191)) - 4096;
      3: return $urandom_range(4000, 4095);
      default: return int'($urandom_range(0, 140)) - 70;
    endcase
  endfunction

  // apb write: setup phase, then access phase; pready is tied high but honored
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      cob_pkg::REG_TYPE:   cfg_type = value[1:0];
      cob_pkg::REG_ENABLE: cfg_enable = value[0];
      cob_pkg::REG_X:      cfg_x = value[12:0];
      cob_pkg::REG_Y:      cfg_y = value[12:0];
      cob_pkg::REG_WIDTH:  cfg_width = value[6:0];
      cob_pkg::REG_HEIGHT: cfg_height = value[7:0];
      cob_pkg::REG_PITCH:  cfg_pitch = value[8:0];
      default: ;
    endcase
  endtask

  task automatic program_cursor(input logic [1:0] ctype, input logic en, input int x,
                                input int y, input int w, input int h, input int pitch);
    reg_write(cob_pkg::REG_TYPE, 32'(ctype));
    reg_write(cob_pkg::REG_ENABLE, 32'(en));
    reg_write(cob_pkg::REG_X, 32'(x));
    reg_write(cob_pkg::REG_Y, 32'(y));
    reg_write(cob_pkg::REG_WIDTH, 32'(w));
    reg_write(cob_pkg::REG_HEIGHT, 32'(h));
    reg_write(cob_pkg::REG_PITCH, 32'(pitch));
    settings_used++;
  endtask

  // block is idle once every queued transaction went in and every result came out
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // input driver: holds each transaction until accepted, then inserts a random gap
  int tx_gap = 0;
  int tx_burst = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        // update the shape image or predict the composited pixel
        if (on_bus.action == cob_pkg::ACT_WRITE) begin
          if (int'(on_bus.shape_addr) < cob_pkg::SHAPE_DEPTH)
            shape_image[on_bus.shape_addr] = on_bus.shape_data;
          writes_accepted++;
        end else begin
          expected_pixels.push_back(composite_pixel(on_bus.pixel_x, on_bus.pixel_y,
                                                    on_bus.pixel_in));
        end
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          on_bus = pending_items.pop_front();
          in_action <= on_bus.action;
          in_shape_addr <= on_bus.shape_addr;
          in_shape_data <= on_bus.shape_data;
          in_pixel_x <= on_bus.pixel_x;
          in_pixel_y <= on_bus.pixel_y;
          in_pixel_in <= on_bus.pixel_in;
          in_valid <= 1'b1;
          tx_gap = idle_length(tx_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compares each accepted result with the oldest prediction
  int rx_stall = 0;
  int rx_burst = 0;
  overlay_result_t oldest;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result with no pixel pending: pixel_out %h covered %b",
                 out_pixel_out, out_covered);
          error_count++;
        end else begin
          oldest = expected_pixels.pop_front();
          if (out_pixel_out !== oldest.pixel_out) begin
            $error("pixel_out: expected %h, got %h", oldest.pixel_out, out_pixel_out);
            error_count++;
          end
          if (out_covered !== oldest.covered) begin
            $error("covered: expected %b, got %b", oldest.covered, out_covered);
            error_count++;
          end
          pixels_checked++;
          if (oldest.covered) covered_seen++;
        end
        rx_stall = idle_length(rx_burst);
      end else if (rx_stall == 0 && $urandom_range(0, 15) == 0) begin
        rx_stall = idle_length(rx_burst);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: any transaction on either channel or the register port restarts the count
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", STALL_LIMIT);
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    logic [1:0]  ctype;
    logic        en;
    int          w, h, pitch;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // out of reset the cursor is off: pixels pass untouched
    queue_pixel(0, 0, 32'h0000_0000);
    queue_pixel(4095, 4095, 32'hFFFF_FFFF);
    wait_idle();

    // color cursor hanging off the top-left corner of the frame
    program_cursor(cob_pkg::TYPE_COLOR, 1'b1, -2, -1, 4, 3, 0);
    queue_write(12'd6, 32'hFF12_3456);
    queue_write(12'd7, 32'h00FF_FFFF);
    queue_pixel(0, 0, 32'h89AB_CDEF);   // opaque word replaces the pixel
    queue_pixel(1, 0, 32'hFFFF_FFFF);   // transparent word: channels wrap
    queue_pixel(2, 0, 32'h1234_5678);   // first column right of the cursor
    queue_pixel(0, 1, $urandom());
    wait_idle();

    // monochrome: the four and/xor combinations along one row
    program_cursor(cob_pkg::TYPE_MONO, 1'b1, 8, 8, 16, 4, 2);
    queue_write(12'd0, 32'hFF5A_C3F0);
    queue_write(12'd1, 32'h3C12_34CC);
    for (int i = 0; i < 4; i++) queue_pixel(8 + 2 * i, 8, 32'hA5A5_5A5A);
    wait_idle();

    // masked color: opaque word xors, any other replaces
    program_cursor(cob_pkg::TYPE_MASKED, 1'b1, 8, 8, 16, 4, 2);
    queue_pixel(8, 8, 32'h0F0F_F0F0);
    queue_pixel(9, 8, 32'h0F0F_F0F0);
    wait_idle();

    // unsupported type leaves the pixel alone
    program_cursor(cob_pkg::TYPE_NONE, 1'b1, 8, 8, 16, 4, 2);
    queue_pixel(8, 8, 32'hDEAD_BEEF);
    wait_idle();

    // oversized cursor clamps; the far corner reads past the end of shape memory
    program_cursor(cob_pkg::TYPE_COLOR, 1'b1, 0, 0, 127, 255, 0);
    queue_pixel(0, 0, 32'h1357_9BDF);
    queue_pixel(64, 0, 32'h2468_ACE0);
    queue_pixel(63, 127, 32'hC0FF_EE11);
    queue_pixel(63, 128, 32'h7777_7777);
    wait_idle();

    // random phases, each with its own cursor setting
    while (items_queued < ITEM_TARGET) begin
      ctype = ($urandom_range(0, 11) == 0) ? cob_pkg::TYPE_NONE : 2'($urandom_range(0, 2));
      en = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 9))
        0: w = 0;
        1: w = 1;
        2: w = cob_pkg::MAX_CURSOR_DIM;
        3: w = 127;
        4: w = $urandom_range(cob_pkg::MAX_CURSOR_DIM + 1, 127);
        default: w = $urandom_range(2, 40);
      endcase
      case ($urandom_range(0, 9))
        0: h = 0;
        1: h = 1;
        2: h = 2 * cob_pkg::MAX_CURSOR_DIM;
        3: h = 255;
        4: h = $urandom_range(2 * cob_pkg::MAX_CURSOR_DIM + 1, 255);
        default: h = $urandom_range(2, 64);
      endcase
      case ($urandom_range(0, 7))
        0: pitch = 0;
        1: pitch = 511;
        2: pitch = $urandom_range(0, 511);
        default: pitch = $urandom_range(1, 12);
      endcase
      program_cursor(ctype, en, pick_position(), pick_position(), w, h, pitch);
      repeat ($urandom_range(60, 200)) queue_random_item();
      wait_idle();
    end

    $display("checked %0d composited pixels (%0d under the cursor) and %0d shape writes",
             pixels_checked, covered_seen, writes_accepted);
    $display("across %0d cursor settings of every type, size extreme and edge position",
             settings_used);
    if (error_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
rtl/cob_pkg.sv
rtl/cob_blend.sv
rtl/cursor_overlay_blend_top.sv
verif/testbench.sv
